[hdl/lcd_readout_formatter_assert.svh]
// Assertion macros shared by the readout formatter RTL.
`ifndef LCD_READOUT_FORMATTER_ASSERT_SVH
`define LCD_READOUT_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define LRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define LRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lcd_rf_pkg.sv]
// Types, constants and the write template table of the readout formatter.
`timescale 1ns / 1ps
`default_nettype none

package lcd_rf_pkg;

    localparam int RUN_LEN         = 24;
    localparam int CNT_W           = $clog2(RUN_LEN);
    localparam int DIGITS          = 4;
    localparam int DIG_SEL_W       = $clog2(DIGITS);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CMD_LINE1 = 8'h80;
    localparam logic [7:0] CMD_DIR   = 8'h80 + 8'd11;
    localparam logic [7:0] CMD_LINE2 = 8'hC0;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // One converted reading: decimal digits, index 3 is the thousands digit.
    typedef struct packed {
        logic [DIGITS-1:0][3:0] ang_dig;
        logic [DIGITS-1:0][3:0] spd_dig;
        logic                   south;
    } t_reading;

    typedef enum logic [2:0] {
        KIND_CMD  = 3'd0,
        KIND_CHAR = 3'd1,
        KIND_ANG  = 3'd2,
        KIND_SPD  = 3'd3,
        KIND_DIR  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [DIG_SEL_W-1:0] sel;
        logic [7:0]           chr;
    } t_tmpl;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
    } t_lcd_write;

    localparam t_tmpl RUN_TABLE [RUN_LEN] = '{
        '{KIND_CMD,  2'd0, CMD_LINE1},
        '{KIND_CHAR, 2'd0, 8'h61},
        '{KIND_CHAR, 2'd0, 8'h72},
        '{KIND_CHAR, 2'd0, 8'h63},
        '{KIND_CHAR, 2'd0, 8'h3A},
        '{KIND_ANG,  2'd3, 8'h00},
        '{KIND_ANG,  2'd2, 8'h00},
        '{KIND_CHAR, 2'd0, CHAR_DOT},
        '{KIND_ANG,  2'd1, 8'h00},
        '{KIND_ANG,  2'd0, 8'h00},
        '{KIND_CMD,  2'd0, CMD_DIR},
        '{KIND_CHAR, 2'd0, 8'h64},
        '{KIND_CHAR, 2'd0, 8'h69},
        '{KIND_CHAR, 2'd0, 8'h72},
        '{KIND_CHAR, 2'd0, 8'h3A},
        '{KIND_DIR,  2'd0, 8'h00},
        '{KIND_CMD,  2'd0, CMD_LINE2},
        '{KIND_CHAR, 2'd0, 8'h76},
        '{KIND_CHAR, 2'd0, 8'h3A},
        '{KIND_SPD,  2'd3, 8'h00},
        '{KIND_SPD,  2'd2, 8'h00},
        '{KIND_CHAR, 2'd0, CHAR_DOT},
        '{KIND_SPD,  2'd1, 8'h00},
        '{KIND_SPD,  2'd0, 8'h00}
    };

    // Builds the bus write at one position of the run.
    function automatic t_lcd_write write_for(logic [CNT_W-1:0] idx, t_reading rd);
        t_tmpl      t;
        t_lcd_write w;
        t = RUN_TABLE[idx];
        w.is_data    = 1'b1;
        w.byte_value = t.chr;
        unique case (t.kind)
            KIND_CMD:  w.is_data = 1'b0;
            KIND_CHAR: w.byte_value = t.chr;
            KIND_ANG:  w.byte_value = CHAR_ZERO + {4'd0, rd.ang_dig[t.sel]};
            KIND_SPD:  w.byte_value = CHAR_ZERO + {4'd0, rd.spd_dig[t.sel]};
            KIND_DIR:  w.byte_value = rd.south ? CHAR_S : CHAR_N;
            default:   w.byte_value = t.chr;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/lcd_rf_front.sv]
// Front end: takes a reading and splits both values into four decimal digits.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rf_front import lcd_rf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_angle_hundredths,
    input  wire logic        i_heading_south,
    input  wire logic [15:0] i_speed_hundredths,
    output logic             o_push_valid,
    input  wire logic        i_push_ready,
    output t_reading         o_push_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } t_state;

    t_state               r_state;
    logic [DIG_SEL_W-1:0] r_step;
    logic [15:0]          r_ang;
    logic [15:0]          r_spd;
    t_reading             r_data;

    logic [31:0] ang_prod, spd_prod;
    logic [15:0] ang_q, spd_q;
    logic [15:0] ang_rem, spd_rem;

    // Division by ten as a multiply by 52429 and a shift by 19, exact for 16-bit values.
    always_comb begin
        ang_prod = {16'd0, r_ang} * 32'd52429;
        spd_prod = {16'd0, r_spd} * 32'd52429;
        ang_q    = {3'd0, ang_prod[31:19]};
        spd_q    = {3'd0, spd_prod[31:19]};
        ang_rem  = r_ang - ({ang_q[12:0], 3'b000} + {ang_q[14:0], 1'b0});
        spd_rem  = r_spd - ({spd_q[12:0], 3'b000} + {spd_q[14:0], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CONV;
                        r_step  <= '0;
                    end
                end
                ST_CONV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == DIG_SEL_W'(DIGITS - 1)) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Digits come out least significant first, one per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_ang        <= i_angle_hundredths;
            r_spd        <= i_speed_hundredths;
            r_data.south <= i_heading_south;
        end else if (r_state == ST_CONV) begin
            r_ang                  <= ang_q;
            r_spd                  <= spd_q;
            r_data.ang_dig[r_step] <= ang_rem[3:0];
            r_data.spd_dig[r_step] <= spd_rem[3:0];
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_push_valid = (r_state == ST_PUSH);
    assign o_push_data  = r_data;

endmodule

`default_nettype wire

[hdl/lcd_rf_fifo.sv]
// Short queue of converted readings between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rf_fifo import lcd_rf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push_valid,
    output logic          o_push_ready,
    input  wire t_reading i_push_data,
    output logic          o_head_valid,
    input  wire logic     i_pop,
    output t_reading      o_head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_reading           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;

    logic push, pop;

    assign o_push_ready = (r_count != CNT_W_Q'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_head_valid;
    assign o_head_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/lcd_rf_back.sv]
// Back end: walks the 24-write run for the queued reading into an output register.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rf_back import lcd_rf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_head_valid,
    input  wire t_reading i_head_data,
    output logic          o_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_is_data,
    output logic [7:0]    o_byte_value,
    output logic          o_last_write
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    logic             r_is_data;
    logic [7:0]       r_byte;
    logic             r_last;

    t_lcd_write wr;
    logic       load;
    logic       at_end;

    assign wr     = write_for(r_cnt, i_head_data);
    assign at_end = (r_cnt == CNT_W'(RUN_LEN - 1));
    // A new write moves in whenever a reading is queued and the register is empty or being drained.
    assign load   = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_cnt   <= at_end ? '0 : r_cnt + 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_data <= wr.is_data;
            r_byte    <= wr.byte_value;
            r_last    <= at_end;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_is_data    = r_is_data;
    assign o_byte_value = r_byte;
    assign o_last_write = r_last;

endmodule

`default_nettype wire

[hdl/lcd_readout_formatter.sv]
// The back end emits one write per cycle from its run counter while the receiver is ready
// and a reading is queued; each reading gives a run of 24 writes.
// The front end converts each reading and runs ahead through the reading queue.
// Reset (synchronous, active low) empties the queue and the output register
// and returns both ends to the start of a run.
`timescale 1ns / 1ps
`default_nettype none
`include "lcd_readout_formatter_assert.svh"

module lcd_readout_formatter import lcd_rf_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_angle_hundredths,
    input  wire logic        i_heading_south,
    input  wire logic [15:0] i_speed_hundredths,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_data,
    output logic [7:0]       o_byte_value,
    output logic             o_last_write
);

    logic     w_push_valid;
    logic     w_push_ready;
    t_reading w_push_data;
    logic     w_head_valid;
    t_reading w_head_data;
    logic     w_pop;

    lcd_rf_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_angle_hundredths (i_angle_hundredths),
        .i_heading_south    (i_heading_south),
        .i_speed_hundredths (i_speed_hundredths),
        .o_push_valid       (w_push_valid),
        .i_push_ready       (w_push_ready),
        .o_push_data        (w_push_data)
    );

    lcd_rf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop),
        .o_head_data  (w_head_data)
    );

    lcd_rf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_data  (w_head_data),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_data    (o_is_data),
        .o_byte_value (o_byte_value),
        .o_last_write (o_last_write)
    );

    `LRF_ASSERT_IMP(a_last_is_data, o_out_valid && o_last_write, o_is_data, "last write is not a data write")
    `LRF_ASSERT_IMP(a_cmd_has_bit7, o_out_valid && !o_is_data, o_byte_value[7], "command without the address bit")
    `LRF_ASSERT_IMP(a_data_range, o_out_valid && o_is_data, (o_byte_value >= CHAR_DOT) && (o_byte_value <= 8'h76), "data byte outside the character set")
    `LRF_ASSERT_NXT(a_run_restart, o_out_valid && i_out_ready && o_last_write, !o_out_valid || (!o_is_data && (o_byte_value == CMD_LINE1)), "run does not restart at line one")

endmodule

`default_nettype wire

[tb/sv/lcd_readout_formatter_tb.sv]
// Self-checking testbench for the LCD readout formatter: readings in, bus writes checked.
`timescale 1ns / 1ps

module lcd_readout_formatter_tb;
    import lcd_rf_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 147;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 30;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
        logic       last_write;
    } t_exp_write;

    // Predicts the 24 bus writes of each reading and checks the writes that come out.
    class lcd_run_scoreboard;
        t_exp_write expected_writes[$];
        t_exp_write run_buf[$];
        int         errors = 0;

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        function void add_write(logic is_data, logic [7:0] value);
            t_exp_write w;
            w.is_data    = is_data;
            w.byte_value = value;
            w.last_write = 1'b0;
            run_buf.push_back(w);
        endfunction

        function void add_text(string s);
            for (int i = 0; i < s.len(); i++) begin
                add_write(1'b1, s[i]);
            end
        endfunction

        // Shows the value as TT.HH from its low four decimal digits.
        function void add_value(logic [15:0] v);
            int unsigned r;
            r = v % 10000;
            add_write(1'b1, CHAR_ZERO + 8'((r / 1000) % 10));
            add_write(1'b1, CHAR_ZERO + 8'((r / 100) % 10));
            add_write(1'b1, CHAR_DOT);
            add_write(1'b1, CHAR_ZERO + 8'((r / 10) % 10));
            add_write(1'b1, CHAR_ZERO + 8'(r % 10));
        endfunction

        function void note_reading(logic [15:0] angle, logic south, logic [15:0] speed);
            run_buf.delete();
            add_write(1'b0, CMD_LINE1);
            add_text("arc:");
            add_value(angle);
            add_write(1'b0, CMD_DIR);
            add_text("dir:");
            add_write(1'b1, south ? CHAR_S : CHAR_N);
            add_write(1'b0, CMD_LINE2);
            add_text("v:");
            add_value(speed);
            run_buf[run_buf.size() - 1].last_write = 1'b1;
            foreach (run_buf[i]) expected_writes.push_back(run_buf[i]);
        endfunction

        task check_write(logic is_data, logic [7:0] value, logic last_write);
            t_exp_write exp_w;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write is_data=%0b byte=%02h last=%0b",
                                          is_data, value, last_write));
                return;
            end
            exp_w = expected_writes.pop_front();
            if (is_data !== exp_w.is_data)
                report_mismatch($sformatf("is_data got %0b want %0b", is_data, exp_w.is_data));
            if (value !== exp_w.byte_value)
                report_mismatch($sformatf("byte_value got %02h want %02h",
                                          value, exp_w.byte_value));
            if (last_write !== exp_w.last_write)
                report_mismatch($sformatf("last_write got %0b want %0b",
                                          last_write, exp_w.last_write));
        endtask

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_angle_hundredths;
    logic        i_heading_south;
    logic [15:0] i_speed_hundredths;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_is_data;
    logic [7:0]  o_byte_value;
    logic        o_last_write;

    lcd_run_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int stall_cycles;

    lcd_readout_formatter DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_angle_hundredths (i_angle_hundredths),
        .i_heading_south    (i_heading_south),
        .i_speed_hundredths (i_speed_hundredths),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_is_data          (o_is_data),
        .o_byte_value       (o_byte_value),
        .o_last_write       (o_last_write)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic offer_reading(logic [15:0] angle, logic south, logic [15:0] speed);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_angle_hundredths <= angle;
        i_heading_south    <= south;
        i_speed_hundredths <= speed;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_reading(angle, south, speed);
        @(negedge i_clk);
    endtask

    // Mixes full-range values with values near the four-digit wrap.
    function automatic logic [15:0] pick_hundredths();
        case ($urandom_range(3))
            0: return 16'($urandom_range(9999));
            1: return 16'($urandom_range(5) * 10000 + 9995 + $urandom_range(9));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_write(o_is_data, o_byte_value, o_last_write);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        sb                 = new();
        stall_cycles       = 0;
        hold_req           = 1'b0;
        send_idle_pct      = 16;
        recv_idle_pct      = 79;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_angle_hundredths = '0;
        i_heading_south    = 1'b0;
        i_speed_hundredths = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, the four-digit wrap and alternating bit patterns.
        offer_reading(16'd0,     1'b0, 16'd0);
        offer_reading(16'd65535, 1'b1, 16'd65535);
        offer_reading(16'd9999,  1'b0, 16'd9999);
        offer_reading(16'd10000, 1'b1, 16'd10000);
        offer_reading(16'd10001, 1'b0, 16'd19999);
        offer_reading(16'd1234,  1'b1, 16'd5678);
        offer_reading(16'd100,   1'b0, 16'd1);
        offer_reading(16'd0,     1'b1, 16'd65535);
        offer_reading(16'd65535, 1'b0, 16'd0);
        offer_reading(16'd20000, 1'b1, 16'd30000);
        offer_reading(16'd9990,  1'b0, 16'd10);
        offer_reading(16'h5555,  1'b1, 16'hAAAA);
        offer_reading(16'hAAAA,  1'b0, 16'h5555);

        // The receiver stops for a long stretch so the input side backs up.
        hold_req = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 16; recv_idle_pct = 79; end
                1: begin send_idle_pct = 79; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                offer_reading(pick_hundredths(), 1'($urandom_range(1)), pick_hundredths());
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
